FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AST_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mfs_pkg.sv
package mfs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 6;
	localparam int TOTAL_W    = 28;
	localparam int MEAN_W     = 16;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic acc;
		logic div_start;
		logic div_step;
		logic res_load;
	} mfs_cmd_t;

	typedef struct packed {
		logic frame_last;
		logic div_last;
	} mfs_sts_t;

endpackage

FILE: rtl/mfs_datapath.sv
module mfs_datapath
	import mfs_pkg::*;
#(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mfs_cmd_t                   cmd,
	output mfs_sts_t                   sts,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       write_enable,
	input  logic [CFG_IDX_W-1:0]       reg_index,
	input  logic [CFG_DATA_W-1:0]      write_data,
	output logic signed [SAMPLE_W-1:0] min_value,
	output logic [POS_W-1:0]           min_row,
	output logic [POS_W-1:0]           min_col,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic [POS_W-1:0]           max_row,
	output logic [POS_W-1:0]           max_col,
	output logic signed [TOTAL_W-1:0]  total,
	output logic signed [MEAN_W-1:0]   mean
);

	localparam int RB   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CB   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RCW  = $clog2(MAX_ROWS + 1);
	localparam int CCW  = $clog2(MAX_COLUMNS + 1);
	localparam int DVW  = RCW + CCW;
	localparam int SUM_W = (SAMPLE_W + RB + CB > TOTAL_W) ? SAMPLE_W + RB + CB : TOTAL_W;
	localparam int CNTW = $clog2(SUM_W);

	logic [CFG_DATA_W-1:0] row_count_q, column_count_q;
	logic [RCW-1:0]        rows_eff;
	logic [CCW-1:0]        cols_eff;

	logic [RB-1:0]              row_idx_q;
	logic [CB-1:0]              col_idx_q;
	logic signed [SUM_W-1:0]    sum_q, sum_nxt;
	logic signed [SAMPLE_W-1:0] min_q, max_q, min_nxt, max_nxt;
	logic [RB-1:0]              min_r_q, max_r_q, min_r_nxt, max_r_nxt;
	logic [CB-1:0]              min_c_q, max_c_q, min_c_nxt, max_c_nxt;
	logic                       first_elem, row_last, col_last;

	// frame snapshot held while the division runs
	logic signed [SAMPLE_W-1:0] snap_min_q, snap_max_q;
	logic [POS_W-1:0]           snap_min_r_q, snap_min_c_q, snap_max_r_q, snap_max_c_q;
	logic signed [TOTAL_W-1:0]  snap_sum_q;

	logic [DVW-1:0]   div_q;
	logic [DVW-1:0]   rem_q;
	logic [SUM_W-1:0] quo_q;
	logic             neg_q;
	logic [CNTW-1:0]  cnt_q;
	logic [DVW:0]     rem_shift;
	logic [SUM_W-1:0] sum_mag;
	logic [SUM_W-1:0] quo_signed;

	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = RCW'(1);
		end else if (32'(row_count_q) > MAX_ROWS) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(row_count_q);
		end
		if (column_count_q == '0) begin
			cols_eff = CCW'(1);
		end else if (32'(column_count_q) > MAX_COLUMNS) begin
			cols_eff = CCW'(MAX_COLUMNS);
		end else begin
			cols_eff = CCW'(column_count_q);
		end
	end

	assign row_last   = (row_idx_q == RB'(rows_eff - RCW'(1)));
	assign col_last   = (col_idx_q == CB'(cols_eff - CCW'(1)));
	assign first_elem = (row_idx_q == '0) && (col_idx_q == '0);

	assign sts.frame_last = row_last && col_last;
	assign sts.div_last   = (cnt_q == CNTW'(SUM_W - 1));

	// first element of a frame seeds sum and both extremes; strict compares keep earliest
	always_comb begin
		sum_nxt   = sum_q + SUM_W'(sample);
		min_nxt   = min_q;
		min_r_nxt = min_r_q;
		min_c_nxt = min_c_q;
		max_nxt   = max_q;
		max_r_nxt = max_r_q;
		max_c_nxt = max_c_q;
		if (first_elem) begin
			sum_nxt   = SUM_W'(sample);
			min_nxt   = sample;
			max_nxt   = sample;
			min_r_nxt = '0;
			min_c_nxt = '0;
			max_r_nxt = '0;
			max_c_nxt = '0;
		end else begin
			if (sample < min_q) begin
				min_nxt   = sample;
				min_r_nxt = row_idx_q;
				min_c_nxt = col_idx_q;
			end
			if (sample > max_q) begin
				max_nxt   = sample;
				max_r_nxt = row_idx_q;
				max_c_nxt = col_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= COUNT_RESET;
			column_count_q <= COUNT_RESET;
			row_idx_q      <= '0;
			col_idx_q      <= '0;
			sum_q          <= '0;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_ROW_COUNT: begin
					row_count_q <= write_data;
				end
				REG_COLUMN_COUNT: begin
					column_count_q <= write_data;
				end
				default: begin
				end
			endcase
			row_idx_q <= '0;
			col_idx_q <= '0;
			sum_q     <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_nxt;
			if (col_last) begin
				col_idx_q <= '0;
				row_idx_q <= row_last ? '0 : row_idx_q + RB'(1);
			end else begin
				col_idx_q <= col_idx_q + CB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			min_q   <= min_nxt;
			max_q   <= max_nxt;
			min_r_q <= min_r_nxt;
			min_c_q <= min_c_nxt;
			max_r_q <= max_r_nxt;
			max_c_q <= max_c_nxt;
		end
	end

	assign sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			snap_min_q   <= min_nxt;
			snap_max_q   <= max_nxt;
			snap_min_r_q <= POS_W'(min_r_nxt);
			snap_min_c_q <= POS_W'(min_c_nxt);
			snap_max_r_q <= POS_W'(max_r_nxt);
			snap_max_c_q <= POS_W'(max_c_nxt);
			snap_sum_q   <= sum_nxt[TOTAL_W-1:0];
		end
	end

	// restoring divider on the magnitude, one quotient bit per cycle
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q <= DVW'(rows_eff) * DVW'(cols_eff);
			rem_q <= '0;
			quo_q <= sum_mag;
			neg_q <= sum_nxt[SUM_W-1];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNTW'(1);
			if (rem_shift >= {1'b0, div_q}) begin
				rem_q <= DVW'(rem_shift - {1'b0, div_q});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[DVW-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo_signed = neg_q ? SUM_W'(-quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			min_value <= snap_min_q;
			min_row   <= snap_min_r_q;
			min_col   <= snap_min_c_q;
			max_value <= snap_max_q;
			max_row   <= snap_max_r_q;
			max_col   <= snap_max_c_q;
			total     <= snap_sum_q;
			mean      <= quo_signed[MEAN_W-1:0];
		end
	end

endmodule

FILE: rtl/mfs_controller.sv
`include "assert_macros.svh"

module mfs_controller
	import mfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  mfs_sts_t sts,
	output mfs_cmd_t cmd
);

	ctl_state_t state_q, state_nxt;
	logic       out_valid_q;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// the last element of a frame waits until the controller is idle again, the division done and its result loaded
	always_comb begin
		state_nxt     = state_q;
		in_ready      = !(sts.frame_last && (state_q != S_IDLE));
		accept        = in_valid && in_ready;
		cmd.acc       = accept;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.res_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && sts.frame_last) begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`AST_SAME(a_start_idle, cmd.div_start, state_q == S_IDLE, "division started while busy")
	`AST_SAME(a_load_free, cmd.res_load, !out_valid_q || out_ready, "result overwritten")
	`AST_SAME(a_stall_cause, !in_ready, sts.frame_last && state_q != S_IDLE, "needless stall")
	`AST_NEXT(a_start_div, cmd.div_start, state_q == S_DIV && out_valid_q == $past(out_valid_q && !out_ready), "divider not running")

endmodule

FILE: rtl/matrix_frame_statistics.sv
// result: accepting a frame's last element starts the SUM_W-bit division of its sum,
// SUM_W being 28 at the default size (one quotient bit per cycle of the divider);
// the result is loaded into the outputs once the previous result has been taken
// throughput: one element per cycle; a frame's last element stalls while the previous
// frame's division runs or its result awaits loading, so the divider limits short frames
// reset: row and column counts go to 64, position counters to zero, no result valid
module matrix_frame_statistics
	import mfs_pkg::*;
#(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] min_value,
	output logic [POS_W-1:0]           min_row,
	output logic [POS_W-1:0]           min_col,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic [POS_W-1:0]           max_row,
	output logic [POS_W-1:0]           max_col,
	output logic signed [TOTAL_W-1:0]  total,
	output logic signed [MEAN_W-1:0]   mean,
	input  logic                       write_enable,
	input  logic [CFG_IDX_W-1:0]       reg_index,
	input  logic [CFG_DATA_W-1:0]      write_data
);

	mfs_cmd_t cmd;
	mfs_sts_t sts;

	mfs_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mfs_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.min_value    (min_value),
		.min_row      (min_row),
		.min_col      (min_col),
		.max_value    (max_value),
		.max_row      (max_row),
		.max_col      (max_col),
		.total        (total),
		.mean         (mean)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import mfs_pkg::*;

	localparam int COUNT_LIMIT   = 64;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int CALM_AFTER    = 1400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int FRAME_CAP     = 256;

	typedef enum {FILL_RANDOM, FILL_NARROW, FILL_EXTREMES, FILL_FLAT} fill_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] min_value;
		logic [POS_W-1:0]           min_row;
		logic [POS_W-1:0]           min_col;
		logic signed [SAMPLE_W-1:0] max_value;
		logic [POS_W-1:0]           max_row;
		logic [POS_W-1:0]           max_col;
		logic signed [TOTAL_W-1:0]  total;
		logic signed [MEAN_W-1:0]   mean;
	} frame_result_t;

	class frame_statistics_board;
		frame_result_t pending_frames[$];
		int mismatches;
		logic [CFG_DATA_W-1:0] row_reg;
		logic [CFG_DATA_W-1:0] column_reg;
		int row_at;
		int column_at;
		int running_total;
		logic signed [SAMPLE_W-1:0] low_value;
		logic signed [SAMPLE_W-1:0] high_value;
		logic [POS_W-1:0] low_row;
		logic [POS_W-1:0] low_column;
		logic [POS_W-1:0] high_row;
		logic [POS_W-1:0] high_column;

		function new();
			mismatches = 0;
			row_reg = COUNT_RESET;
			column_reg = COUNT_RESET;
			restart();
		endfunction

		function void restart();
			row_at = 0;
			column_at = 0;
			running_total = 0;
			low_value = '0;
			high_value = '0;
			low_row = '0;
			low_column = '0;
			high_row = '0;
			high_column = '0;
		endfunction

		// zero acts as one, anything past the limit saturates
		static function int clamp_count(logic [CFG_DATA_W-1:0] v, int limit);
			if (v == 0) return 1;
			if (int'(v) > limit) return limit;
			return int'(v);
		endfunction

		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_ROW_COUNT) row_reg = v;
			else if (idx == REG_COLUMN_COUNT) column_reg = v;
			// any write drops the frame in progress
			restart();
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] s);
			int rows;
			int columns;
			frame_result_t done;
			rows = clamp_count(row_reg, COUNT_LIMIT);
			columns = clamp_count(column_reg, COUNT_LIMIT);
			if (row_at == 0 && column_at == 0) begin
				running_total = s;
				low_value = s;
				high_value = s;
				low_row = '0;
				low_column = '0;
				high_row = '0;
				high_column = '0;
			end else begin
				running_total += s;
				if (s < low_value) begin
					low_value = s;
					low_row = POS_W'(row_at);
					low_column = POS_W'(column_at);
				end
				if (s > high_value) begin
					high_value = s;
					high_row = POS_W'(row_at);
					high_column = POS_W'(column_at);
				end
			end
			if (column_at + 1 < columns) begin
				column_at++;
				return;
			end
			column_at = 0;
			if (row_at + 1 < rows) begin
				row_at++;
				return;
			end
			row_at = 0;
			done.min_value = low_value;
			done.min_row = low_row;
			done.min_col = low_column;
			done.max_value = high_value;
			done.max_row = high_row;
			done.max_col = high_column;
			done.total = TOTAL_W'(running_total);
			// integer division truncates toward zero
			done.mean = MEAN_W'(running_total / (rows * columns));
			pending_frames.push_back(done);
		endfunction

		function string describe(frame_result_t r);
			return $sformatf("min %0d at (%0d,%0d) max %0d at (%0d,%0d) total %0d mean %0d",
				r.min_value, r.min_row, r.min_col, r.max_value, r.max_row,
				r.max_col, r.total, r.mean);
		endfunction

		function void check_frame(frame_result_t seen);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %s", describe(seen));
				return;
			end
			want = pending_frames.pop_front();
			if (seen.min_value !== want.min_value || seen.min_row !== want.min_row ||
					seen.min_col !== want.min_col || seen.max_value !== want.max_value ||
					seen.max_row !== want.max_row || seen.max_col !== want.max_col ||
					seen.total !== want.total || seen.mean !== want.mean) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result differs at %0t", $time);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(seen));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] min_value;
	logic [POS_W-1:0] min_row;
	logic [POS_W-1:0] min_col;
	logic signed [SAMPLE_W-1:0] max_value;
	logic [POS_W-1:0] max_row;
	logic [POS_W-1:0] max_col;
	logic signed [TOTAL_W-1:0] total;
	logic signed [MEAN_W-1:0] mean;
	logic write_enable;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0] write_data;

	frame_statistics_board board = new();
	int idle_pct = 20;
	int hold_left = 0;
	int cycle_count = 0;

	matrix_frame_statistics DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_value    (min_value),
		.min_row      (min_row),
		.min_col      (min_col),
		.max_value    (max_value),
		.max_row      (max_row),
		.max_col      (max_col),
		.total        (total),
		.mean         (mean),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("matrix_frame_statistics: mismatch");
			$finish;
		end
	end

	// receiver stalls in bursts of random length
	always @(posedge clk) begin
		if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else if (hold_left == 1) begin
			hold_left <= 0;
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			hold_left <= $urandom_range(1, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		frame_result_t seen;
		if (arst_n) begin
			// check before noting the input so a fresh expectation is never matched early
			if (out_valid && out_ready) begin
				seen.min_value = min_value;
				seen.min_row = min_row;
				seen.min_col = min_col;
				seen.max_value = max_value;
				seen.max_row = max_row;
				seen.max_col = max_col;
				seen.total = total;
				seen.mean = mean;
				board.check_frame(seen);
			end
			if (in_valid && in_ready) board.take_sample(sample);
			if (write_enable) board.load_register(reg_index, write_data);
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 16) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= value;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	// wait until every frame result is out, then let the design drain before going on
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'($urandom_range(COUNT_LIMIT + 1, 127));
			3: return CFG_DATA_W'(COUNT_LIMIT);
			default: return CFG_DATA_W'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_t fill,
			logic signed [SAMPLE_W-1:0] base);
		case (fill)
			// narrow range makes ties common
			FILL_NARROW: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
			FILL_EXTREMES: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return '0;
					default: return '1;
				endcase
			end
			FILL_FLAT: return base;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int extreme_samples[5] = '{-32768, 32767, 0, -1, 1};
		int tie_frames[16] = '{5, -7, -7, 5, -1, -2, 0, 0,
			-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767};
		int random_items;
		int frame_size;
		int frames;
		int tail;
		logic [CFG_DATA_W-1:0] row_pick;
		logic [CFG_DATA_W-1:0] column_pick;
		logic signed [SAMPLE_W-1:0] base;
		fill_t fill;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		write_enable <= 1'b0;
		reg_index <= REG_ROW_COUNT;
		write_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial frame at reset size, dropped by the register writes
		repeat (3) send_sample(SAMPLE_W'($urandom));
		settle();
		write_register(REG_ROW_COUNT, '0);
		write_register(REG_COLUMN_COUNT, CFG_DATA_W'(1));
		foreach (extreme_samples[i]) send_sample(SAMPLE_W'(extreme_samples[i]));
		settle();
		write_register(REG_ROW_COUNT, CFG_DATA_W'(2));
		write_register(REG_COLUMN_COUNT, CFG_DATA_W'(2));
		foreach (tie_frames[i]) send_sample(SAMPLE_W'(tie_frames[i]));

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 3))
				0, 1: idle_pct = 0;
				2: idle_pct = 10;
				default: idle_pct = 30;
			endcase
			if (random_items > CALM_AFTER) idle_pct = 0;
			row_pick = pick_count();
			column_pick = pick_count();
			if (frame_statistics_board::clamp_count(row_pick, COUNT_LIMIT) *
					frame_statistics_board::clamp_count(column_pick, COUNT_LIMIT) > FRAME_CAP)
				column_pick = CFG_DATA_W'($urandom_range(1, 4));
			frame_size = frame_statistics_board::clamp_count(row_pick, COUNT_LIMIT) *
				frame_statistics_board::clamp_count(column_pick, COUNT_LIMIT);
			if ($urandom_range(0, 1) == 1) begin
				write_register(REG_ROW_COUNT, row_pick);
				write_register(REG_COLUMN_COUNT, column_pick);
			end else begin
				write_register(REG_COLUMN_COUNT, column_pick);
				write_register(REG_ROW_COUNT, row_pick);
			end
			frames = (frame_size >= 64) ? 1 : $urandom_range(1, 4);
			// sometimes leave a frame unfinished so the next write drops it
			tail = (frame_size > 1 && $urandom_range(0, 3) == 0) ?
				$urandom_range(1, frame_size - 1) : 0;
			for (int f = 0; f < frames; f++) begin
				fill = fill_t'($urandom_range(0, 3));
				base = pick_sample(FILL_RANDOM, '0);
				for (int k = 0; k < frame_size; k++) send_sample(pick_sample(fill, base));
			end
			for (int k = 0; k < tail; k++) send_sample(pick_sample(FILL_RANDOM, '0));
			random_items += frames * frame_size + tail;
		end

		settle();
		if (board.mismatches == 0 && board.pending_frames.size() == 0) begin
			$display("matrix_frame_statistics: match");
		end else begin
			$display("matrix_frame_statistics: mismatch");
		end
		$finish;
	end

endmodule

FILE: matrix_frame_statistics.f
+incdir+rtl
rtl/mfs_pkg.sv
rtl/mfs_datapath.sv
rtl/mfs_controller.sv
rtl/matrix_frame_statistics.sv
dv/tb.sv
